@@ design/assert_macros.svh @@
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is asserted
`define DTSF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define DTSF_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/dtsf_pkg.sv @@
// types and constants of the depth temporal stability filter
package dtsf_pkg;

	localparam int DEPTH_W = 16;
	localparam int COL_W   = 10;
	localparam int ROW_W   = 9;
	localparam int CNT_W   = 6;
	localparam int SUM_W   = 23;
	localparam int SQ_W    = 40;
	localparam int NSL_W   = 5;
	localparam int VAR_W   = 16;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 16;
	localparam int WARM_W  = 7;

	localparam logic [DEPTH_W-1:0] EMPTY_DEPTH = 16'd32000;
	localparam logic [7:0]         BIG_RAW     = 8'd80;
	localparam logic [WARM_W-1:0]  WARM_FRAMES = 7'd60;
	localparam logic [CNT_W-1:0]   COUNT_MAX   = 6'd63;
	localparam logic [SUM_W-1:0]   SUM_MAX     = {SUM_W{1'b1}};
	localparam logic [SQ_W-1:0]    SQ_MAX      = {SQ_W{1'b1}};

	// mean divider: dividend is sum plus half the count
	localparam int DIV_N_W   = SUM_W + 1;
	localparam int DIV_STEPS = DIV_N_W;
	localparam int DIV_CNT_W = 5;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ROI_MIN_X   = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROI_MAX_X   = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROI_MIN_Y   = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ROI_MAX_Y   = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_SLOTS   = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CEILING     = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_FOLLOW_BIG  = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_VAR     = 4'd7;

	// commands from the controller
	typedef struct packed {
		logic clr_step;
		logic accept;
		logic addr_p;
		logic addr_r;
		logic ring_rd;
		logic latch_old;
		logic mul;
		logic base;
		logic add;
		logic sub;
		logic ring_wr;
		logic stab1;
		logic stab2;
		logic div_start;
		logic div_step;
		logic hold;
		logic wb;
		logic out_load;
	} dtsf_cmd_t;

	// status back to the controller
	typedef struct packed {
		logic roi_hit;
		logic clr_done;
		logic take;
		logic ring_last;
		logic move;
		logic div_last;
		logic out_busy;
	} dtsf_sts_t;

endpackage

@@ design/dtsf_ram.sv @@
// generic single write port ram with registered read
module dtsf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ design/dtsf_ctrl.sv @@
// controller state machine of the filter
module dtsf_ctrl import dtsf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  dtsf_sts_t sts,
	output dtsf_cmd_t cmd
);

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_ADDR, S_ADDR2, S_RD, S_OLD, S_MUL, S_BASE, S_ADD,
		S_SUB, S_RING, S_STAB1, S_STAB2, S_STAB3, S_DIV, S_HOLD, S_WB, S_OUT
	} state_t;

	state_t state_q;
	logic   in_ready_q;

	assign in_ready = in_ready_q;

	// state and ready register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			in_ready_q <= 1'b0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					if (sts.clr_done) begin
						state_q    <= S_IDLE;
						in_ready_q <= 1'b1;
					end
				end
				S_IDLE: begin
					if (in_valid && in_ready_q) begin
						state_q    <= S_ADDR;
						in_ready_q <= 1'b0;
					end
				end
				S_ADDR:  state_q <= sts.roi_hit ? S_ADDR2 : S_OUT;
				S_ADDR2: state_q <= S_RD;
				S_RD:    state_q <= S_OLD;
				S_OLD:   state_q <= S_MUL;
				S_MUL:   state_q <= S_BASE;
				S_BASE:  state_q <= S_ADD;
				S_ADD:   state_q <= S_SUB;
				S_SUB:   state_q <= sts.take ? S_RING : S_STAB1;
				S_RING: begin
					if (sts.ring_last) begin
						state_q <= S_STAB1;
					end
				end
				S_STAB1: state_q <= S_STAB2;
				S_STAB2: state_q <= S_STAB3;
				S_STAB3: state_q <= sts.move ? S_DIV : S_WB;
				S_DIV: begin
					if (sts.div_last) begin
						state_q <= S_HOLD;
					end
				end
				S_HOLD:  state_q <= S_WB;
				S_WB:    state_q <= S_OUT;
				S_OUT: begin
					if (!sts.out_busy) begin
						state_q    <= S_IDLE;
						in_ready_q <= 1'b1;
					end
				end
				default: begin
					state_q    <= S_IDLE;
					in_ready_q <= 1'b1;
				end
			endcase
		end
	end

	// command decode
	always_comb begin
		cmd           = '0;
		cmd.clr_step  = (state_q == S_CLEAR);
		cmd.accept    = (state_q == S_IDLE) && in_valid && in_ready_q;
		cmd.addr_p    = (state_q == S_ADDR);
		cmd.addr_r    = (state_q == S_ADDR2);
		cmd.ring_rd   = (state_q == S_RD);
		cmd.latch_old = (state_q == S_OLD);
		cmd.mul       = (state_q == S_MUL);
		cmd.base      = (state_q == S_BASE);
		cmd.add       = (state_q == S_ADD);
		cmd.sub       = (state_q == S_SUB);
		cmd.ring_wr   = (state_q == S_RING);
		cmd.stab1     = (state_q == S_STAB1);
		cmd.stab2     = (state_q == S_STAB2);
		cmd.div_start = (state_q == S_STAB3) && sts.move;
		cmd.div_step  = (state_q == S_DIV);
		cmd.hold      = (state_q == S_HOLD);
		cmd.wb        = (state_q == S_WB);
		cmd.out_load  = (state_q == S_OUT) && !sts.out_busy;
	end

endmodule

@@ design/dtsf_dp.sv @@
// datapath: registers, pixel memories, statistics arithmetic and mean divider
module dtsf_dp import dtsf_pkg::*; #(
	parameter int FRAME_WIDTH  = 640,
	parameter int FRAME_HEIGHT = 480,
	parameter int MAX_SLOTS    = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dtsf_cmd_t             cmd,
	output dtsf_sts_t             sts,
	input  logic [DEPTH_W-1:0]    depth,
	input  logic [COL_W-1:0]      col,
	input  logic [ROW_W-1:0]      row,
	input  logic                  frame_end,
	input  logic                  cfg_valid,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  out_ready,
	output logic                  out_valid,
	output logic [DEPTH_W-1:0]    filtered_depth,
	output logic                  inside_region,
	output logic                  warmed_up
);

	localparam int PIXELS  = FRAME_WIDTH * FRAME_HEIGHT;
	localparam int PIX_W   = $clog2(PIXELS);
	localparam int RING_D  = PIXELS * MAX_SLOTS;
	localparam int RING_AW = $clog2(RING_D);
	localparam int SW      = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int NW      = $clog2(MAX_SLOTS + 1);
	localparam int REC_W   = MAX_SLOTS + DEPTH_W + SQ_W + SUM_W + CNT_W;

	// configuration registers
	logic [COL_W-1:0]   roi_min_x_q, roi_max_x_q;
	logic [ROW_W-1:0]   roi_min_y_q, roi_max_y_q;
	logic [NSL_W-1:0]   num_slots_q;
	logic [DEPTH_W-1:0] ceiling_q;
	logic               follow_q;
	logic [VAR_W-1:0]   max_var_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			roi_min_x_q <= '0;
			roi_max_x_q <= 10'd640;
			roi_min_y_q <= '0;
			roi_max_y_q <= 9'd480;
			num_slots_q <= 5'd16;
			ceiling_q   <= '0;
			follow_q    <= 1'b0;
			max_var_q   <= 16'd256;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_ROI_MIN_X:  roi_min_x_q <= cfg_data[COL_W-1:0];
				REG_ROI_MAX_X:  roi_max_x_q <= cfg_data[COL_W-1:0];
				REG_ROI_MIN_Y:  roi_min_y_q <= cfg_data[ROW_W-1:0];
				REG_ROI_MAX_Y:  roi_max_y_q <= cfg_data[ROW_W-1:0];
				REG_NUM_SLOTS:  num_slots_q <= cfg_data[NSL_W-1:0];
				REG_CEILING:    ceiling_q   <= cfg_data;
				REG_FOLLOW_BIG: follow_q    <= cfg_data[0];
				REG_MAX_VAR:    max_var_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// slots in use, slot pointer fix-up and region test at the input
	logic [NW-1:0] n_use;
	logic [SW-1:0] sp_q, ptr_use, ptr_next;
	logic [NW-1:0] ptr_inc;
	logic          in_roi;

	always_comb begin
		if (num_slots_q == '0) begin
			n_use = NW'(1);
		end else if (32'(num_slots_q) > MAX_SLOTS) begin
			n_use = NW'(MAX_SLOTS);
		end else begin
			n_use = NW'(num_slots_q);
		end
		ptr_use  = (NW'(sp_q) >= n_use) ? '0 : sp_q;
		ptr_inc  = NW'(ptr_use) + NW'(1);
		ptr_next = frame_end ? ((ptr_inc >= n_use) ? '0 : SW'(ptr_inc)) : ptr_use;
		in_roi   = (col >= roi_min_x_q) && (col < roi_max_x_q) &&
		           (row >= roi_min_y_q) && (row < roi_max_y_q) &&
		           (32'(col) < FRAME_WIDTH) && (32'(row) < FRAME_HEIGHT);
	end

	// frame-level state: slot pointer and warm-up, updated at each input transfer
	logic [WARM_W-1:0] wf_q, wf_inc;
	logic              warm_q;

	assign wf_inc = wf_q + WARM_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q   <= '0;
			wf_q   <= '0;
			warm_q <= 1'b0;
		end else if (cmd.accept) begin
			sp_q <= ptr_next;
			if (frame_end && !warm_q) begin
				wf_q <= wf_inc;
				if (wf_inc > WARM_FRAMES) begin
					warm_q <= 1'b1;
				end
			end
		end
	end

	// item registers
	logic [DEPTH_W-1:0] d_q;
	logic [COL_W-1:0]   col_q;
	logic [ROW_W-1:0]   row_q;
	logic               inside_q, take_q, warm_out_q;
	logic [SW-1:0]      ptr_q;
	logic [NW-1:0]      n_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			d_q        <= depth;
			col_q      <= col;
			row_q      <= row;
			inside_q   <= in_roi;
			take_q     <= depth > ceiling_q;
			warm_out_q <= warm_q;
			ptr_q      <= ptr_use;
			n_q        <= n_use;
		end
	end

	// addresses
	logic [PIX_W-1:0]   p_q;
	logic [RING_AW-1:0] ring_addr_q;

	always_ff @(posedge clk) begin
		if (cmd.addr_p) begin
			p_q <= PIX_W'(32'(row_q) * FRAME_WIDTH + 32'(col_q));
		end
		if (cmd.addr_r) begin
			ring_addr_q <= RING_AW'(32'(ptr_q) * PIXELS + 32'(p_q));
		end
	end

	// clearing pass over the per-pixel statistics
	logic [PIX_W-1:0] clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clr_step && !sts.clr_done) begin
			clr_addr_q <= clr_addr_q + PIX_W'(1);
		end
	end

	// working statistics of the pixel
	logic [CNT_W-1:0]     c_q;
	logic [SUM_W-1:0]     s_q;
	logic [SQ_W-1:0]      q_q;
	logic [DEPTH_W-1:0]   h_q;
	logic [MAX_SLOTS-1:0] vm_q;
	logic [DEPTH_W-1:0]   old_q;
	logic                 old_valid_q, big_q;
	logic [21:0]          dc_q;
	logic [12:0]          c80_q;
	logic [31:0]          dd_q, oo_q;

	// statistics memory
	logic             st_we;
	logic [PIX_W-1:0] st_waddr;
	logic [REC_W-1:0] st_wdata, st_rdata;

	assign st_we    = cmd.clr_step | cmd.wb;
	assign st_waddr = cmd.clr_step ? clr_addr_q : p_q;
	assign st_wdata = cmd.clr_step ?
		{{MAX_SLOTS{1'b0}}, EMPTY_DEPTH, {SQ_W{1'b0}}, {SUM_W{1'b0}}, {CNT_W{1'b0}}} :
		{vm_q, h_q, q_q, s_q, c_q};

	dtsf_ram #(.WIDTH(REC_W), .DEPTH(PIXELS)) u_stats (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.re    (cmd.addr_r),
		.raddr (p_q),
		.rdata (st_rdata)
	);

	// sample ring memory
	logic [RING_AW-1:0] ring_wa_q;
	logic [NW-1:0]      ring_k_q;
	logic [DEPTH_W-1:0] ring_rdata;

	dtsf_ram #(.WIDTH(DEPTH_W), .DEPTH(RING_D)) u_ring (
		.clk   (clk),
		.we    (cmd.ring_wr),
		.waddr (ring_wa_q),
		.wdata (d_q),
		.re    (cmd.ring_rd),
		.raddr (ring_addr_q),
		.rdata (ring_rdata)
	);

	// big change test and rewrite base
	logic [SUM_W-1:0]     dc_ext, big_diff;
	logic                 big_now;
	logic [SUM_W:0]       s_big;
	logic [SQ_W:0]        q_big;
	logic [MAX_SLOTS-1:0] fill_mask;

	always_comb begin
		dc_ext   = SUM_W'(dc_q);
		big_diff = (s_q > dc_ext) ? (s_q - dc_ext) : (dc_ext - s_q);
		big_now  = take_q && follow_q && (c_q != '0) && (big_diff >= SUM_W'(c80_q));
		s_big    = (SUM_W+1)'(d_q * n_q);
		q_big    = (SQ_W+1)'(dd_q * n_q);
		for (int k = 0; k < MAX_SLOTS; k++) begin
			fill_mask[k] = (k < 32'(n_q));
		end
	end

	// add arithmetic with a carry bit for saturation
	logic [CNT_W:0]  c_add;
	logic [SUM_W:0]  s_add;
	logic [SQ_W:0]   q_add;

	assign c_add = {1'b0, c_q} + (CNT_W+1)'(1);
	assign s_add = {1'b0, s_q} + (SUM_W+1)'(d_q);
	assign q_add = {1'b0, q_q} + (SQ_W+1)'(dd_q);

	// stability products
	logic [11:0]        cc_q;
	logic [45:0]        ss_q, qc_q;
	logic [21:0]        hc_q;
	logic [27:0]        mvcc_q;
	logic               hyst_q, cpos_q;
	logic [SUM_W-1:0]   hc_ext, h_diff;
	logic [NW:0]        min_cnt;
	logic [46:0]        var_rhs;

	always_comb begin
		hc_ext  = SUM_W'(hc_q);
		h_diff  = (s_q > hc_ext) ? (s_q - hc_ext) : (hc_ext - s_q);
		min_cnt = ({1'b0, n_q} + (NW+1)'(1)) >> 1;
		var_rhs = 47'(mvcc_q) + 47'(ss_q);
	end

	// mean divider, one quotient bit a cycle
	logic [DIV_N_W-1:0]   num_q, quo_q;
	logic [CNT_W-1:0]     rem_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [CNT_W:0]       rem_sh;
	logic                 rem_ge;

	assign rem_sh = {rem_q, num_q[DIV_N_W-1]};
	assign rem_ge = rem_sh >= {1'b0, c_q};

	always_ff @(posedge clk) begin
		if (cmd.ring_rd) begin
			c_q  <= st_rdata[CNT_W-1:0];
			s_q  <= st_rdata[CNT_W +: SUM_W];
			q_q  <= st_rdata[CNT_W+SUM_W +: SQ_W];
			h_q  <= st_rdata[CNT_W+SUM_W+SQ_W +: DEPTH_W];
			vm_q <= st_rdata[REC_W-1 -: MAX_SLOTS];
		end
		if (cmd.latch_old) begin
			old_q       <= ring_rdata;
			old_valid_q <= vm_q[ptr_q];
		end
		if (cmd.mul) begin
			dc_q  <= 22'(d_q * c_q);
			c80_q <= 13'(BIG_RAW * c_q);
			dd_q  <= d_q * d_q;
			oo_q  <= old_q * old_q;
		end
		// rewrite the pixel history on a big jump
		if (cmd.base) begin
			big_q <= big_now;
			if (big_now) begin
				c_q  <= CNT_W'(n_q);
				s_q  <= s_big[SUM_W] ? SUM_MAX : s_big[SUM_W-1:0];
				q_q  <= q_big[SQ_W] ? SQ_MAX : q_big[SQ_W-1:0];
				vm_q <= vm_q | fill_mask;
			end
		end
		// add the new sample and set up the ring writes
		if (cmd.add) begin
			ring_k_q  <= '0;
			ring_wa_q <= big_q ? RING_AW'(p_q) : ring_addr_q;
			if (take_q) begin
				c_q <= c_add[CNT_W] ? COUNT_MAX : c_add[CNT_W-1:0];
				s_q <= s_add[SUM_W] ? SUM_MAX : s_add[SUM_W-1:0];
				q_q <= q_add[SQ_W] ? SQ_MAX : q_add[SQ_W-1:0];
				vm_q[ptr_q] <= 1'b1;
			end
		end
		// remove the replaced sample
		if (cmd.sub && take_q && old_valid_q) begin
			c_q <= (c_q != '0) ? c_q - CNT_W'(1) : '0;
			s_q <= (s_q >= SUM_W'(old_q)) ? s_q - SUM_W'(old_q) : '0;
			q_q <= (q_q >= SQ_W'(oo_q)) ? q_q - SQ_W'(oo_q) : '0;
		end
		if (cmd.ring_wr) begin
			ring_k_q  <= ring_k_q + NW'(1);
			ring_wa_q <= ring_wa_q + RING_AW'(PIXELS);
		end
		if (cmd.stab1) begin
			cc_q <= c_q * c_q;
			ss_q <= s_q * s_q;
			qc_q <= 46'(q_q * c_q);
			hc_q <= h_q * c_q;
		end
		if (cmd.stab2) begin
			mvcc_q <= max_var_q * cc_q;
			hyst_q <= h_diff >= SUM_W'({c_q, 2'b00});
			cpos_q <= (c_q != '0) && ((CNT_W+1)'(c_q) >= (CNT_W+1)'(min_cnt));
		end
		if (cmd.div_start) begin
			num_q     <= {1'b0, s_q} + DIV_N_W'(c_q >> 1);
			quo_q     <= '0;
			rem_q     <= '0;
			div_cnt_q <= '0;
		end
		if (cmd.div_step) begin
			num_q     <= num_q << 1;
			quo_q     <= {quo_q[DIV_N_W-2:0], rem_ge};
			rem_q     <= rem_ge ? CNT_W'(rem_sh - {1'b0, c_q}) : CNT_W'(rem_sh);
			div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
		end
		// saturate the mean into the held value
		if (cmd.hold) begin
			h_q <= (|quo_q[DIV_N_W-1:DEPTH_W]) ? {DEPTH_W{1'b1}} : quo_q[DEPTH_W-1:0];
		end
	end

	// output register
	logic               out_valid_q;
	logic [DEPTH_W-1:0] out_depth_q;
	logic               out_inside_q, out_warm_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_depth_q  <= inside_q ? h_q : '0;
			out_inside_q <= inside_q;
			out_warm_q   <= warm_out_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign filtered_depth = out_depth_q;
	assign inside_region  = out_inside_q;
	assign warmed_up      = out_warm_q;

	// status
	always_comb begin
		sts           = '0;
		sts.roi_hit   = inside_q;
		sts.clr_done  = (32'(clr_addr_q) == PIXELS - 1);
		sts.take      = take_q;
		sts.ring_last = !big_q || ((ring_k_q + NW'(1)) == n_q);
		sts.move      = cpos_q && hyst_q && (47'(qc_q) <= var_rhs);
		sts.div_last  = (32'(div_cnt_q) == DIV_STEPS - 1);
		sts.out_busy  = out_valid_q && !out_ready;
	end

endmodule

@@ design/depth_temporal_stability_filter_unit.sv @@
// top level of the per-pixel depth temporal stability filter
//
// channel  direction  handshake               payload
// in       sink       in_valid / in_ready     depth, col, row, frame_end
// out      source     out_valid / out_ready   filtered_depth, inside_region, warmed_up
// cfg      sink       cfg_valid / cfg_ready   cfg_index, cfg_data
//
// one item at a time: outside the region an item goes from the address state to the
// output state; inside, it runs the read, arithmetic and stability states, plus one
// ring write for a sample above the ceiling (slots in use on a big jump), plus the
// serial mean divider when the held value moves. after reset a clearing pass writes
// all FRAME_WIDTH*FRAME_HEIGHT statistics entries while in_ready stays low.
// a result waits in the output register while the next item is taken in.
module depth_temporal_stability_filter_unit import dtsf_pkg::*; #(
	parameter int FRAME_WIDTH  = 640,
	parameter int FRAME_HEIGHT = 480,
	parameter int MAX_SLOTS    = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [DEPTH_W-1:0]    depth,
	input  logic [COL_W-1:0]      col,
	input  logic [ROW_W-1:0]      row,
	input  logic                  frame_end,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [DEPTH_W-1:0]    filtered_depth,
	output logic                  inside_region,
	output logic                  warmed_up,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	dtsf_cmd_t cmd;
	dtsf_sts_t sts;

	// registers take a write in any cycle
	assign cfg_ready = 1'b1;

	dtsf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	dtsf_dp #(
		.FRAME_WIDTH  (FRAME_WIDTH),
		.FRAME_HEIGHT (FRAME_HEIGHT),
		.MAX_SLOTS    (MAX_SLOTS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.depth          (depth),
		.col            (col),
		.row            (row),
		.frame_end      (frame_end),
		.cfg_valid      (cfg_valid),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.out_ready      (out_ready),
		.out_valid      (out_valid),
		.filtered_depth (filtered_depth),
		.inside_region  (inside_region),
		.warmed_up      (warmed_up)
	);

endmodule

@@ design/dtsf_checker.sv @@
// port-level checker for the filter, bound to the top level
`include "assert_macros.svh"

module dtsf_checker import dtsf_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [DEPTH_W-1:0] filtered_depth,
	input logic               inside_region,
	input logic               cfg_ready
);

	// a stalled result holds
	`DTSF_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(filtered_depth), "stalled result changed")

	// pixels outside the region give zero
	`DTSF_ASSERT(a_outside_zero, out_valid && !inside_region |-> filtered_depth == '0, "outside pixel not zero")

	// one item in flight: no transfer in the cycle after a transfer
	`DTSF_ASSERT(a_one_item, in_valid && in_ready |=> !in_ready, "input taken twice in a row")

	// no input taken and no result offered during reset
	`DTSF_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> !in_ready && !out_valid, "handshake active in reset")

	// registers are always writable
	`DTSF_ASSERT(a_cfg_ready, cfg_ready, "configuration port stalled")

endmodule

bind depth_temporal_stability_filter_unit dtsf_checker u_chk (.*);

@@ tb/dtsf_checker.sv @@
// checker for the depth temporal stability filter: predicts every result and compares it
`timescale 1ns / 100ps
module dtsf_tb_checker import dtsf_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  logic [DEPTH_W-1:0]    depth,
	input  logic [COL_W-1:0]      col,
	input  logic [ROW_W-1:0]      row,
	input  logic                  frame_end,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  logic [DEPTH_W-1:0]    filtered_depth,
	input  logic                  inside_region,
	input  logic                  warmed_up,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    errors,
	output int                    pending
);
	localparam int unsigned FW = 640;
	localparam int unsigned FH = 480;
	localparam int unsigned NPIX = FW * FH;
	localparam int unsigned SLOTS_MAX = 16;

	typedef struct packed {
		logic [DEPTH_W-1:0] held;
		logic               ins;
		logic               warm;
	} pixel_result_t;

	// register copies
	logic [COL_W-1:0]   min_x, max_x;
	logic [ROW_W-1:0]   min_y, max_y;
	logic [NSL_W-1:0]   slots_reg;
	logic [DEPTH_W-1:0] ceiling;
	logic               follow;
	logic [VAR_W-1:0]   var_limit;

	// per pixel statistics, sparse; absent entries hold their reset value
	logic [DEPTH_W-1:0] ring_val [int unsigned];
	bit                 ring_ok  [int unsigned];
	longint unsigned    cnt_of   [int unsigned];
	longint unsigned    sum_of   [int unsigned];
	longint unsigned    sq_of    [int unsigned];
	longint unsigned    held_of  [int unsigned];
	int unsigned        slot_ptr;
	int unsigned        frames;
	bit                 warm;

	pixel_result_t expected_results [$];

	function automatic longint unsigned absdiff(longint unsigned a, longint unsigned b);
		return a > b ? a - b : b - a;
	endfunction

	// one pixel through the filter
	task automatic filter_pixel(input logic [DEPTH_W-1:0] d_in, input logic [COL_W-1:0] c_in,
			input logic [ROW_W-1:0] r_in, input logic fe);
		int unsigned n, p, ri, e;
		longint unsigned d, c, s, q, h, m, old;
		bit old_ok, ins, warm_before;
		pixel_result_t res;
		n = slots_reg == 0 ? 1 : (slots_reg > SLOTS_MAX ? SLOTS_MAX : slots_reg);
		warm_before = warm;
		if (slot_ptr >= n)
			slot_ptr = 0;
		ins = c_in >= min_x && c_in < max_x && r_in >= min_y && r_in < max_y &&
			c_in < FW && r_in < FH;
		res.held = '0;
		if (ins) begin
			p = r_in * FW + c_in;
			ri = slot_ptr * NPIX + p;
			if (!cnt_of.exists(p)) begin
				cnt_of[p] = 0; sum_of[p] = 0; sq_of[p] = 0; held_of[p] = EMPTY_DEPTH;
			end
			// sample above the ceiling enters the ring
			if (d_in > ceiling) begin
				d = d_in;
				old_ok = ring_ok.exists(ri) ? ring_ok[ri] : 1'b0;
				old = ring_val.exists(ri) ? ring_val[ri] : EMPTY_DEPTH;
				ring_val[ri] = d_in;
				ring_ok[ri] = 1'b1;
				c = cnt_of[p]; s = sum_of[p]; q = sq_of[p];
				// big jump rewrites every slot in use of the pixel's ring
				if (follow && c > 0 && absdiff(s, d * c) >= BIG_RAW * c) begin
					for (int unsigned k = 0; k < n; k++) begin
						e = k * NPIX + p;
						ring_val[e] = d_in;
						ring_ok[e] = 1'b1;
					end
					c = n;
					s = d * n > SUM_MAX ? SUM_MAX : d * n;
					q = d * d * n > SQ_MAX ? SQ_MAX : d * d * n;
				end
				c = c + 1 > COUNT_MAX ? COUNT_MAX : c + 1;
				s = s + d > SUM_MAX ? SUM_MAX : s + d;
				q = q + d * d > SQ_MAX ? SQ_MAX : q + d * d;
				if (old_ok) begin
					c = c >= 1 ? c - 1 : 0;
					s = s >= old ? s - old : 0;
					q = q >= old * old ? q - old * old : 0;
				end
				cnt_of[p] = c; sum_of[p] = s; sq_of[p] = q;
			end
			// stable pixel: held value follows the mean with hysteresis
			c = cnt_of[p]; s = sum_of[p]; q = sq_of[p];
			if (c > 0 && c >= (n + 1) / 2 && q * c <= longint'(var_limit) * c * c + s * s) begin
				h = held_of[p];
				if (absdiff(s, h * c) >= 4 * c) begin
					m = (s + c / 2) / c;
					held_of[p] = m > 16'hFFFF ? 16'hFFFF : m;
				end
			end
			res.held = DEPTH_W'(held_of[p]);
		end
		// frame end moves the slot and the warm-up count
		if (fe) begin
			slot_ptr++;
			if (slot_ptr >= n)
				slot_ptr = 0;
			if (!warm) begin
				frames = (frames + 1) & 7'h7F;
				if (frames > WARM_FRAMES)
					warm = 1'b1;
			end
		end
		res.ins = ins;
		res.warm = warm_before;
		expected_results = {expected_results, res};
	endtask

	task automatic report(input string what, input longint unsigned want, input longint unsigned got);
		$display("mismatch %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
		errors++;
	endtask

	// reset state
	initial begin
		errors = 0;
		min_x = 0; max_x = 640; min_y = 0; max_y = 480;
		slots_reg = 16; ceiling = 0; follow = 0; var_limit = 256;
		slot_ptr = 0; frames = 0; warm = 0;
	end

	assign pending = expected_results.size();

	// watch the three channels
	always @(posedge clk) begin
		pixel_result_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_ROI_MIN_X:  min_x = cfg_data[COL_W-1:0];
					REG_ROI_MAX_X:  max_x = cfg_data[COL_W-1:0];
					REG_ROI_MIN_Y:  min_y = cfg_data[ROW_W-1:0];
					REG_ROI_MAX_Y:  max_y = cfg_data[ROW_W-1:0];
					REG_NUM_SLOTS:  slots_reg = cfg_data[NSL_W-1:0];
					REG_CEILING:    ceiling = cfg_data;
					REG_FOLLOW_BIG: follow = cfg_data[0];
					REG_MAX_VAR:    var_limit = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$display("unexpected result transfer at %0t", $realtime);
					errors++;
				end else begin
					want = expected_results.pop_front();
					if (filtered_depth !== want.held)
						report("filtered_depth", want.held, filtered_depth);
					if (inside_region !== want.ins)
						report("inside_region", want.ins, inside_region);
					if (warmed_up !== want.warm)
						report("warmed_up", want.warm, warmed_up);
				end
			end
			if (in_valid && in_ready)
				filter_pixel(depth, col, row, frame_end);
		end
	end

endmodule

@@ tb/tb_depth_temporal_stability_filter_unit.sv @@
// testbench top for the depth temporal stability filter: stimulus and verdict
`timescale 1ns / 100ps
module tb_depth_temporal_stability_filter_unit;
	import dtsf_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 4'd15;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int DRAIN_CYCLES = 100;
	localparam int HOLD_CYCLES = 400;

	logic                  clk, arst_n;
	logic                  in_valid, in_ready;
	logic [DEPTH_W-1:0]    depth;
	logic [COL_W-1:0]      col;
	logic [ROW_W-1:0]      row;
	logic                  frame_end;
	logic                  out_valid, out_ready;
	logic [DEPTH_W-1:0]    filtered_depth;
	logic                  inside_region, warmed_up;
	logic                  cfg_valid, cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    errors, pending;
	int                    cycles;
	bit                    gaps_on;
	bit                    hold_req;

	// pixel pool for the random part
	logic [COL_W-1:0]   pool_col  [16];
	logic [ROW_W-1:0]   pool_row  [16];
	logic [DEPTH_W-1:0] pool_base [16];

	depth_temporal_stability_filter_unit uut (.*);

	dtsf_tb_checker checker_i (.*);

	// clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// one pixel transfer, with an optional gap before it
	task automatic send_pixel(input logic [DEPTH_W-1:0] d, input logic [COL_W-1:0] c,
			input logic [ROW_W-1:0] r, input logic fe);
		int gap;
		gap = gaps_on ? $urandom_range(0, 4) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		depth <= d; col <= c; row <= r; frame_end <= fe;
		in_valid <= 1'b1;
		#1;
		while (!in_ready) begin
			@(negedge clk);
			#1;
		end
		@(negedge clk);
	endtask

	// register write, only while the block is idle (left to the caller, unchecked)
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_index <= idx; cfg_data <= val; cfg_valid <= 1'b1;
		#1;
		while (!cfg_ready) begin
			@(negedge clk);
			#1;
		end
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// wait for every result, then let the block settle
	task automatic quiesce;
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic set_config(input int mnx, input int mxx, input int mny, input int mxy,
			input int ns, input int ceil, input int fb, input int mv);
		quiesce();
		write_reg(REG_ROI_MIN_X, CFG_DATA_W'(mnx));
		write_reg(REG_ROI_MAX_X, CFG_DATA_W'(mxx));
		write_reg(REG_ROI_MIN_Y, CFG_DATA_W'(mny));
		write_reg(REG_ROI_MAX_Y, CFG_DATA_W'(mxy));
		write_reg(REG_NUM_SLOTS, CFG_DATA_W'(ns));
		write_reg(REG_CEILING, CFG_DATA_W'(ceil));
		write_reg(REG_FOLLOW_BIG, CFG_DATA_W'(fb));
		write_reg(REG_MAX_VAR, CFG_DATA_W'(mv));
	endtask

	// receiver with random stalls and one long hold-off
	initial begin
		int gap;
		out_ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				gap = HOLD_CYCLES;
			end else
				gap = gaps_on ? $urandom_range(0, 4) : 0;
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready <= 1'b1;
			#1;
			while (!out_valid) begin
				@(negedge clk);
				#1;
			end
			@(negedge clk);
		end
	end

	// stimulus
	initial begin
		int pick, d;
		cycles = 0;
		hold_req = 1'b0;
		gaps_on = 1'b1;
		in_valid = 1'b0; depth = '0; col = '0; row = '0; frame_end = 1'b0;
		cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
		arst_n = 1'b0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// directed: extremes, ceiling, out of frame, big jump, frame end
		write_reg(REG_UNUSED, 16'hFFFF);
		set_config(0, 640, 0, 480, 4, 0, 1, 65535);
		send_pixel(0, 0, 0, 0);
		repeat (3) send_pixel(16'hFFFF, 0, 0, 0);
		send_pixel(8, 639, 479, 0);
		send_pixel(16, 639, 479, 1);
		send_pixel(100, 10'h3FF, 0, 0);
		send_pixel(100, 0, 9'h1FF, 0);
		repeat (3) send_pixel(1000, 5, 5, 0);
		send_pixel(2000, 5, 5, 1);
		send_pixel(2001, 5, 5, 0);
		set_config(10, 639, 5, 479, 0, 999, 0, 0);
		send_pixel(1000, 9, 5, 0);
		send_pixel(1000, 10, 5, 0);
		send_pixel(1000, 638, 478, 0);
		send_pixel(1000, 639, 478, 0);
		send_pixel(1000, 10, 4, 1);
		send_pixel(1001, 10, 5, 0);

		// random phases under several settings
		for (int ph = 0; ph < 7; ph++) begin
			case (ph)
				0: set_config(0, 640, 0, 480, 16, 0, 0, 256);
				1: set_config(0, 1023, 0, 511, 1, 0, 1, 65535);
				2: set_config($urandom_range(0, 200), $urandom_range(300, 640),
					$urandom_range(0, 150), $urandom_range(250, 480), 0, 50, 1, 64);
				3: set_config(0, 640, 0, 480, 31, $urandom_range(0, 65535), 1,
					$urandom_range(0, 65535));
				4: set_config(300, 300, 400, 100, 7, 0, 0, 512);
				5: set_config(0, 640, 0, 480, $urandom_range(2, 15), 8, 1, 1024);
				default: set_config(0, 640, 0, 480, 16, 0, 0, 65535);
			endcase
			gaps_on = ph != 6;
			for (int k = 0; k < 16; k++) begin
				pool_col[k] = COL_W'($urandom_range(0, 639));
				pool_row[k] = ROW_W'($urandom_range(0, 479));
				pool_base[k] = DEPTH_W'($urandom_range(100, 60000));
			end
			for (int i = 0; i < 270; i++) begin
				if (ph == 0 && i == 100)
					hold_req = 1'b1;
				pick = $urandom_range(0, 15);
				if ($urandom_range(0, 99) < 5)
					pool_base[pick] = DEPTH_W'($urandom_range(0, 65000));
				d = pool_base[pick] + $urandom_range(0, 6);
				if ($urandom_range(0, 99) < 8)
					d = $urandom_range(0, 65535);
				if ($urandom_range(0, 99) < 5)
					send_pixel(DEPTH_W'(d), COL_W'($urandom_range(0, 1023)),
						ROW_W'($urandom_range(0, 511)), $urandom_range(0, 99) < 5);
				else
					send_pixel(DEPTH_W'(d), pool_col[pick], pool_row[pick],
						$urandom_range(0, 99) < 5);
			end
		end

		quiesce();
		if (errors == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
